@@ rtl/rmq_pkg.sv @@
// shared types and defaults for the rotation matrix to quaternion pipeline
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // which component dominates the conversion
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

  // per-word side information that rides along the pipeline
  typedef struct packed {
    logic [3:0] neg;
    logic       degen;
    branch_e    branch;
  } side_t;

endpackage

@@ rtl/rmq_front.sv @@
// front end: branch select, scaled components, magnitudes, squares and norm sum
`timescale 1ns / 1ps
module rmq_front #(
  parameter int DW = 16,
  parameter int FW = 14,
  parameter int SW = 17,
  parameter int NW = 36
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [DW-1:0]  m_i [9],
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NW-1:0]         n2_o,
  output logic [SW-1:0]         mag_o [4],
  output rmq_pkg::side_t        side_o
);
  import rmq_pkg::*;

  localparam int CW  = DW + 2;
  localparam int MW  = DW + 1;
  localparam int SMAX = MW - SW;
  localparam int NST = 6;
  localparam logic signed [CW-1:0] One = {{(CW-1){1'b0}}, 1'b1} << FW;

  logic [NST-1:0] valid_q;
  logic [NST-1:0] valid_in;
  logic [NST:0]   en;

  // stall chain: a stage moves when empty or when the next one moves
  assign en[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end
  assign in_ready_o = en[0];
  assign valid_in   = {valid_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  // stage 1: trace and largest diagonal index
  logic signed [DW-1:0] m1_q [9];
  logic signed [CW-1:0] trace1_q, trace1_d;
  logic [1:0]           idx1_q, idx1_d;

  always_comb begin
    logic c1, c2;
    logic signed [DW-1:0] mii;
    trace1_d = CW'(m_i[0]) + CW'(m_i[4]) + CW'(m_i[8]);
    c1  = m_i[4] > m_i[0];
    mii = c1 ? m_i[4] : m_i[0];
    c2  = m_i[8] > mii;
    idx1_d = c2 ? 2'd2 : (c1 ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m1_q     <= m_i;
      trace1_q <= trace1_d;
      idx1_q   <= idx1_d;
    end
  end

  // stage 2: components scaled by twice the root
  logic signed [CW-1:0] e [9];
  logic signed [CW-1:0] comp2_q [4], comp2_d [4];
  side_t                side2_q, side2_d;

  for (genvar i = 0; i < 9; i++) begin : g_ext
    assign e[i] = CW'(m1_q[i]);
  end

  always_comb begin
    logic signed [CW-1:0] r;
    side2_d.neg = '0;
    case (idx1_q)
      2'd1: begin
        r = e[4] - e[8] - e[0] + One;
        comp2_d[0] = e[2] - e[6];
        comp2_d[1] = e[1] + e[3];
        comp2_d[2] = r;
        comp2_d[3] = e[7] + e[5];
        side2_d.branch = BR_Y;
      end
      2'd2: begin
        r = e[8] - e[0] - e[4] + One;
        comp2_d[0] = e[3] - e[1];
        comp2_d[1] = e[2] + e[6];
        comp2_d[2] = e[5] + e[7];
        comp2_d[3] = r;
        side2_d.branch = BR_Z;
      end
      default: begin
        r = e[0] - e[4] - e[8] + One;
        comp2_d[0] = e[7] - e[5];
        comp2_d[1] = r;
        comp2_d[2] = e[3] + e[1];
        comp2_d[3] = e[6] + e[2];
        side2_d.branch = BR_X;
      end
    endcase
    if (trace1_q > 0) begin
      r = trace1_q + One;
      comp2_d[0] = r;
      comp2_d[1] = e[7] - e[5];
      comp2_d[2] = e[2] - e[6];
      comp2_d[3] = e[3] - e[1];
      side2_d.branch = BR_TRACE;
    end
    side2_d.degen = (r <= 0);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      comp2_q <= comp2_d;
      side2_q <= side2_d;
    end
  end

  // stage 3: sign and magnitude
  logic [MW-1:0] mag3_q [4], mag3_d [4];
  side_t         side3_q, side3_d;

  always_comb begin
    logic signed [CW-1:0] neg_v;
    side3_d = side2_q;
    for (int c = 0; c < 4; c++) begin
      neg_v = -comp2_q[c];
      side3_d.neg[c] = comp2_q[c][CW-1];
      mag3_d[c] = comp2_q[c][CW-1] ? neg_v[MW-1:0] : comp2_q[c][MW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mag3_q  <= mag3_d;
      side3_q <= side3_d;
    end
  end

  // stage 4: common right shift so every magnitude stays below 2^30
  logic [SW-1:0] smag4_q [4], smag4_d [4];
  side_t         side4_q;

  always_comb begin
    logic [MW-1:0] orv;
    int sh;
    orv = mag3_q[0] | mag3_q[1] | mag3_q[2] | mag3_q[3];
    sh = SMAX;
    for (int t = SMAX; t >= 0; t--) begin
      if ((orv >> (30 + t)) == '0) sh = t;
    end
    for (int c = 0; c < 4; c++) begin
      smag4_d[c] = SW'(mag3_q[c] >> sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      smag4_q <= smag4_d;
      side4_q <= side3_q;
    end
  end

  // stage 5: squares
  logic [2*SW-1:0] sq5_q [4];
  logic [SW-1:0]   smag5_q [4];
  side_t           side5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int c = 0; c < 4; c++) begin
        sq5_q[c] <= (2*SW)'(smag4_q[c]) * (2*SW)'(smag4_q[c]);
      end
      smag5_q <= smag4_q;
      side5_q <= side4_q;
    end
  end

  // stage 6: squared norm
  logic [NW-1:0] n2_q;
  logic [SW-1:0] smag6_q [4];
  side_t         side6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      n2_q    <= NW'(sq5_q[0]) + NW'(sq5_q[1]) + NW'(sq5_q[2]) + NW'(sq5_q[3]);
      smag6_q <= smag5_q;
      side6_q <= side5_q;
    end
  end

  assign out_valid_o = valid_q[NST-1];
  assign n2_o        = n2_q;
  assign mag_o       = smag6_q;
  assign side_o      = side6_q;

endmodule

@@ rtl/rmq_sqrt.sv @@
// pipelined integer square root of the squared norm, one result bit per stage
`timescale 1ns / 1ps
module rmq_sqrt #(
  parameter int SW = 17,
  parameter int NW = 36,
  parameter int RW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [NW-1:0]   n2_i,
  input  logic [SW-1:0]   mag_i [4],
  input  rmq_pkg::side_t  side_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [RW-1:0]   len_o,
  output logic [SW-1:0]   mag_o [4],
  output rmq_pkg::side_t  side_o
);
  import rmq_pkg::*;

  logic [RW-1:0] valid_q;
  logic [RW-1:0] valid_in;
  logic [RW:0]   en;
  logic [NW-1:0] rem_q [RW], res_q [RW];
  logic [NW-1:0] rem_in [RW], res_in [RW];
  logic [NW-1:0] rem_d [RW], res_d [RW];
  logic [SW-1:0] mag_q [RW][4];
  logic [SW-1:0] mag_in [RW][4];
  side_t         side_q [RW];
  side_t         side_in [RW];

  // stall chain
  assign en[RW] = out_ready_i;
  for (genvar k = 0; k < RW; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end
  assign in_ready_o = en[0];
  assign valid_in   = {valid_q[RW-2:0], in_valid_i};

  // stage inputs
  assign rem_in[0]  = n2_i;
  assign res_in[0]  = '0;
  assign mag_in[0]  = mag_i;
  assign side_in[0] = side_i;
  for (genvar k = 1; k < RW; k++) begin : g_in
    assign rem_in[k]  = rem_q[k-1];
    assign res_in[k]  = res_q[k-1];
    assign mag_in[k]  = mag_q[k-1];
    assign side_in[k] = side_q[k-1];
  end

  // one restoring root step per stage
  always_comb begin
    logic [NW-1:0] bitv, trial;
    for (int k = 0; k < RW; k++) begin
      bitv  = NW'(1) << (2 * (RW - 1 - k));
      trial = res_in[k] + bitv;
      if (rem_in[k] >= trial) begin
        rem_d[k] = rem_in[k] - trial;
        res_d[k] = (res_in[k] >> 1) + bitv;
      end else begin
        rem_d[k] = rem_in[k];
        res_d[k] = res_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < RW; k++) begin
        if (en[k]) valid_q[k] <= valid_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RW; k++) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d[k];
        res_q[k]  <= res_d[k];
        mag_q[k]  <= mag_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign out_valid_o = valid_q[RW-1];
  assign len_o       = res_q[RW-1][RW-1:0];
  assign mag_o       = mag_q[RW-1];
  assign side_o      = side_q[RW-1];

endmodule

@@ rtl/rmq_div.sv @@
// pipelined restoring division of each magnitude by the norm, rounded half up
`timescale 1ns / 1ps
module rmq_div #(
  parameter int SW = 17,
  parameter int RW = 18,
  parameter int FW = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [RW-1:0]   len_i,
  input  logic [SW-1:0]   mag_i [4],
  input  rmq_pkg::side_t  side_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [FW:0]     quot_o [4],
  output rmq_pkg::side_t  side_o
);
  import rmq_pkg::*;

  localparam int QW   = FW + 1;
  localparam int NUMW = SW + FW + 2;
  localparam int STG  = QW + 1;

  logic [STG-1:0]  valid_q;
  logic [STG-1:0]  valid_in;
  logic [STG:0]    en;
  logic [NUMW-1:0] rem_q [STG][4], rem_d [STG][4];
  logic [QW-1:0]   quo_q [STG][4], quo_d [STG][4];
  logic [RW:0]     den_q [STG], den_d [STG];
  side_t           side_q [STG], side_d [STG];

  // stall chain
  assign en[STG] = out_ready_i;
  for (genvar k = 0; k < STG; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end
  assign in_ready_o = en[0];
  assign valid_in   = {valid_q[STG-2:0], in_valid_i};

  // stage 0 forms numerator and divisor, later stages each settle one bit
  always_comb begin
    logic [NUMW-1:0] dsh;
    int b;
    den_d[0]  = {len_i, 1'b0};
    side_d[0] = side_i;
    side_d[0].degen = side_i.degen || (len_i == '0);
    for (int c = 0; c < 4; c++) begin
      rem_d[0][c] = (NUMW'(mag_i[c]) << (FW + 1)) + NUMW'(len_i);
      quo_d[0][c] = '0;
    end
    for (int k = 1; k < STG; k++) begin
      b = QW - k;
      den_d[k]  = den_q[k-1];
      side_d[k] = side_q[k-1];
      dsh = NUMW'(den_q[k-1]) << b;
      for (int c = 0; c < 4; c++) begin
        if (rem_q[k-1][c] >= dsh) begin
          rem_d[k][c] = rem_q[k-1][c] - dsh;
          quo_d[k][c] = quo_q[k-1][c] | (QW'(1) << b);
        end else begin
          rem_d[k][c] = rem_q[k-1][c];
          quo_d[k][c] = quo_q[k-1][c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < STG; k++) begin
        if (en[k]) valid_q[k] <= valid_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < STG; k++) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d[k];
        quo_q[k]  <= quo_d[k];
        den_q[k]  <= den_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign out_valid_o = valid_q[STG-1];
  assign quot_o      = quo_q[STG-1];
  assign side_o      = side_q[STG-1];

endmodule

@@ rtl/rotation_matrix_to_quaternion_top.sv @@
// top level: rotation matrix to unit quaternion, fully pipelined
`timescale 1ns / 1ps
// Converts one 3x3 rotation matrix per word into a normalized quaternion.
// Input stream s_axis: nine signed matrix entries m00..m22 in tdata.
// Output stream m_axis: quat_w..quat_z in tdata, branch and degenerate
// flag in tuser. One result word for every input word, in order.
// Throughput: one matrix per cycle unless m_axis_tready stalls the output.
// The pipe holds 6 front stages (branch, components, magnitudes, shift,
// squares, norm sum), one root stage per root bit (DATA_WIDTH+2 while
// DATA_WIDTH is below 30, else 31), FRAC_BITS+2 division stages (the first
// forms numerator and divisor, each later one settles one quotient bit) and
// the output register. The root and divider stage counts set the latency.
// Reset clears all valid bits; data registers are not reset.
// When m_axis_tready is low, full stages hold and empty stages still fill,
// so s_axis_tready drops only once every stage holds a word.
// A non-positive radicand or a zero norm gives zero components with the
// degenerate flag set; the branch is still reported.
module rotation_matrix_to_quaternion_top #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // branch_taken[1:0], degenerate[2]
  output logic [2:0]                             m_axis_tuser
);
  import rmq_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int MW  = DW + 1;
  localparam int SW  = (MW > 30) ? 30 : MW;
  localparam int NW  = 2 * SW + 2;
  localparam int RW  = SW + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int XW  = ((QW > DW) ? QW : DW) + 1;
  localparam logic signed [XW-1:0] Hi = (XW'(1) << (DW - 1)) - XW'(1);
  localparam logic signed [XW-1:0] Lo = -Hi - XW'(1);

  // unpack the matrix word
  logic signed [DW-1:0] m_in [9];
  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign m_in[i] = s_axis_tdata[i*DW +: DW];
  end

  logic          f_valid, f_ready;
  logic [NW-1:0] f_n2;
  logic [SW-1:0] f_mag [4];
  side_t         f_side;

  rmq_front #(.DW(DW), .FW(FRAC_BITS), .SW(SW), .NW(NW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .m_i        (m_in),
    .out_valid_o(f_valid),
    .out_ready_i(f_ready),
    .n2_o       (f_n2),
    .mag_o      (f_mag),
    .side_o     (f_side)
  );

  logic          r_valid, r_ready;
  logic [RW-1:0] r_len;
  logic [SW-1:0] r_mag [4];
  side_t         r_side;

  rmq_sqrt #(.SW(SW), .NW(NW), .RW(RW)) u_sqrt (
    .clk_i, .rst_ni,
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .n2_i       (f_n2),
    .mag_i      (f_mag),
    .side_i     (f_side),
    .out_valid_o(r_valid),
    .out_ready_i(r_ready),
    .len_o      (r_len),
    .mag_o      (r_mag),
    .side_o     (r_side)
  );

  logic          d_valid, d_ready;
  logic [QW-1:0] d_quot [4];
  side_t         d_side;

  rmq_div #(.SW(SW), .RW(RW), .FW(FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .in_valid_i (r_valid),
    .in_ready_o (r_ready),
    .len_i      (r_len),
    .mag_i      (r_mag),
    .side_i     (r_side),
    .out_valid_o(d_valid),
    .out_ready_i(d_ready),
    .quot_o     (d_quot),
    .side_o     (d_side)
  );

  // output register: sign, zeroing and saturation
  logic          out_valid_q;
  logic [DW-1:0] quat_q [4], quat_d [4];
  side_t         side_q;

  assign d_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    logic signed [XW-1:0] v;
    for (int c = 0; c < 4; c++) begin
      v = XW'(d_quot[c]);
      if (d_side.neg[c]) v = -v;
      if (v > Hi) v = Hi;
      if (v < Lo) v = Lo;
      quat_d[c] = d_side.degen ? '0 : v[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (d_ready) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready) begin
      quat_q <= quat_d;
      side_q <= d_side;
    end
  end

  // pack the result word
  always_comb begin
    m_axis_tdata = '0;
    for (int c = 0; c < 4; c++) begin
      m_axis_tdata[c*DW +: DW] = quat_q[c];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {side_q.degen, side_q.branch};

endmodule

@@ sim/tb.sv @@
// testbench for the rotation matrix to quaternion pipeline, checked against a predictor
`timescale 1ns / 1ps
module tb;
  import rmq_pkg::*;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam int LATENCY = 41;

  typedef struct {
    logic signed [DW-1:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [DW-1:0] q [4];
    branch_e              branch;
    logic                 degen;
  } quat_t;

  typedef struct {
    logic signed [DW-1:0] m [9];
    bit                   has_exp;
    logic signed [DW-1:0] q [4];
    branch_e              branch;
    logic                 degen;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  quat_t   quat_queue[$];
  matrix_t mat_queue[$];
  int      fail_count;
  int      sent_count;
  bit      stim_done;
  bit      hold_rx;
  string   q_names [4] = '{"quat_w", "quat_x", "quat_y", "quat_z"};

  rotation_matrix_to_quaternion_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // shoemake conversion with exact normalization
  function automatic quat_t matrix_to_quat(matrix_t mt);
    quat_t           res;
    longint          a [3][3];
    longint          comp [4];
    longint          one, tr, rad, qs;
    longint unsigned mag [4];
    longint unsigned maxmag, n2, len, num, qm, lim;
    int              i, j, k, s;
    bit              degen;
    one    = longint'(1) << FB;
    maxmag = 0;
    n2     = 0;
    s      = 0;
    degen  = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) a[r][c] = mt.m[r*3+c];
    tr = a[0][0] + a[1][1] + a[2][2];
    if (tr > 0) begin
      res.branch = BR_TRACE;
      rad     = tr + one;
      comp[0] = rad;
      comp[1] = a[2][1] - a[1][2];
      comp[2] = a[0][2] - a[2][0];
      comp[3] = a[1][0] - a[0][1];
    end else begin
      i = 0;
      if (a[1][1] > a[0][0]) i = 1;
      if (a[2][2] > a[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      res.branch = branch_e'(i + 1);
      rad         = a[i][i] - a[j][j] - a[k][k] + one;
      comp[0]     = a[k][j] - a[j][k];
      comp[1 + i] = rad;
      comp[1 + j] = a[j][i] + a[i][j];
      comp[1 + k] = a[k][i] + a[i][k];
    end
    if (rad <= 0) degen = 1;
    for (int c = 0; c < 4; c++) begin
      mag[c] = comp[c] < 0 ? longint'(-comp[c]) : comp[c];
      if (mag[c] > maxmag) maxmag = mag[c];
    end
    while ((maxmag >> s) >= (64'd1 << 30)) s++;
    for (int c = 0; c < 4; c++) begin
      mag[c] >>= s;
      n2 += mag[c] * mag[c];
    end
    len = int_sqrt(n2);
    if (len == 0) degen = 1;
    lim = (64'd1 << (DW - 1)) - 1;
    for (int c = 0; c < 4; c++) begin
      qs = 0;
      if (!degen) begin
        num = mag[c] << FB;
        qm  = (2 * num + len) / (2 * len);
        qs  = comp[c] < 0 ? -longint'(qm) : longint'(qm);
      end
      if (qs > longint'(lim)) qs = lim;
      if (qs < -longint'(lim) - 1) qs = -longint'(lim) - 1;
      res.q[c] = qs[DW-1:0];
    end
    res.degen = degen;
    return res;
  endfunction

  // one word into the block, waiting for acceptance
  task automatic send_matrix(matrix_t mt);
    logic [143:0] word;
    word = '0;
    for (int e = 0; e < 9; e++) word[e*DW +: DW] = mt.m[e];
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    mat_queue.push_back(mt);
    quat_queue.push_back(matrix_to_quat(mt));
    sent_count++;
  endtask

  task automatic idle_sender(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic signed [DW-1:0] rnd_entry();
    case ($urandom_range(0, 5))
      0: return DW'($urandom);
      1: return $urandom_range(0, 3) == 0 ? 16'sh8000 : 16'sh7fff;
      default: return DW'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // random matrix: axis-aligned sign permutation plus small tilt noise, or, one time in five, random entries
  function automatic matrix_t rnd_matrix();
    matrix_t mt;
    int      perm [3];
    int      t;
    int      mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      for (int e = 0; e < 9; e++) mt.m[e] = rnd_entry();
      return mt;
    end
    perm = '{0, 1, 2};
    for (int e = 2; e > 0; e--) begin
      t = $urandom_range(0, e);
      {perm[e], perm[t]} = {perm[t], perm[e]};
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        mt.m[r*3+c] = DW'($signed($urandom_range(0, 2 * 3000)) - 3000);
        if (perm[r] == c)
          mt.m[r*3+c] = $urandom_range(0, 1) ? DW'(16384 - int'($urandom_range(0, 3000)))
                                             : DW'(-16384 + int'($urandom_range(0, 3000)));
      end
    return mt;
  endfunction

  // directed rows
  dir_row_t dir_rows [$];

  function automatic dir_row_t mk_row(int v [9], bit chk, int w, int x, int y, int z,
                                      branch_e br, logic dg);
    dir_row_t row;
    for (int e = 0; e < 9; e++) row.m[e] = DW'(v[e]);
    row.has_exp = chk;
    row.q       = '{DW'(w), DW'(x), DW'(y), DW'(z)};
    row.branch  = br;
    row.degen   = dg;
    return row;
  endfunction

  initial begin
    // identity
    dir_rows.push_back(mk_row('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}, 1,
                              16384, 0, 0, 0, BR_TRACE, 1'b0));
    // 180 degrees about x, y, z
    dir_rows.push_back(mk_row('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 1,
                              0, 16384, 0, 0, BR_X, 1'b0));
    dir_rows.push_back(mk_row('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}, 1,
                              0, 0, 16384, 0, BR_Y, 1'b0));
    dir_rows.push_back(mk_row('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}, 1,
                              0, 0, 0, 16384, BR_Z, 1'b0));
    // all zero: x path, radicand one
    dir_rows.push_back(mk_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1,
                              0, 16384, 0, 0, BR_X, 1'b0));
    // diagonal extremes: the radicand stays positive off the trace path
    dir_rows.push_back(mk_row('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}, 1,
                              0, 16384, 0, 0, BR_X, 1'b0));
    dir_rows.push_back(mk_row('{-32768, 0, 0, 0, -16384, 0, 0, 0, 32767}, 1,
                              0, 0, 0, 16384, BR_Z, 1'b0));
    dir_rows.push_back(mk_row('{-32768, 0, 0, 0, 0, 0, 0, 0, 32767}, 0,
                              0, 0, 0, 0, BR_TRACE, 1'b0));
    // ties on the diagonal, lower index wins
    dir_rows.push_back(mk_row('{-8192, 5, 7, 9, -8192, 11, 13, 17, -8192}, 0,
                              0, 0, 0, 0, BR_TRACE, 1'b0));
    dir_rows.push_back(mk_row('{-16384, 5, 7, 9, 0, 11, 13, 17, 0}, 0,
                              0, 0, 0, 0, BR_TRACE, 1'b0));
    // extremes of every entry
    dir_rows.push_back(mk_row('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
                              0, 0, 0, 0, 0, BR_TRACE, 1'b0));
    dir_rows.push_back(mk_row('{-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768}, 0, 0, 0, 0, 0, BR_TRACE, 1'b0));
    dir_rows.push_back(mk_row('{32767, -32768, 32767, -32768, 32767, -32768, 32767,
                                -32768, 32767}, 0, 0, 0, 0, 0, BR_TRACE, 1'b0));
    dir_rows.push_back(mk_row('{-32768, 32767, -32768, 32767, -32768, 32767, -32768,
                                32767, -32768}, 0, 0, 0, 0, 0, BR_TRACE, 1'b0));
    dir_rows.push_back(mk_row('{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 0,
                              0, 0, 0, 0, BR_TRACE, 1'b0));
    // 90 degrees about z, and a large off-diagonal on the y path
    dir_rows.push_back(mk_row('{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}, 0,
                              0, 0, 0, 0, BR_TRACE, 1'b0));
    dir_rows.push_back(mk_row('{-32768, 32767, -32768, 32767, 32767, 32767, -32768,
                                32767, -32768}, 0, 0, 0, 0, 0, BR_TRACE, 1'b0));
  end

  // stimulus
  initial begin
    matrix_t mt;
    int      burst;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    stim_done     = 1'b0;
    fail_count    = 0;
    sent_count    = 0;
    rst_ni        = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);

    // directed table
    foreach (dir_rows[n]) begin
      for (int e = 0; e < 9; e++) mt.m[e] = dir_rows[n].m[e];
      send_matrix(mt);
      if (dir_rows[n].has_exp) begin
        quat_queue[$].q      = dir_rows[n].q;
        quat_queue[$].branch = dir_rows[n].branch;
        quat_queue[$].degen  = dir_rows[n].degen;
      end
      @(negedge clk_i);
    end

    // pause until the pipe drains
    s_axis_tvalid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk_i);
    @(negedge clk_i);

    // random bursts; the receiver holds off once in the middle
    for (int n = 0; n < 900; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < 900; b++, n++) begin
        send_matrix(rnd_matrix());
        @(negedge clk_i);
      end
      if ($urandom_range(0, 2) != 0) begin
        idle_sender($urandom_range(1, 8));
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // long receiver hold-off while the sender keeps offering words
  initial begin
    hold_rx = 1'b0;
    wait (stim_done == 0 && rst_ni && sent_count > 300);
    @(negedge clk_i);
    hold_rx = 1'b1;
    repeat (200) @(posedge clk_i);
    @(negedge clk_i);
    hold_rx = 1'b0;
  end

  // receiver stall pattern
  initial begin
    int cyc;
    cyc = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_rx) m_axis_tready <= 1'b0;
      else if ((cyc / 300) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0) && ((cyc % 7) != 3);
    end
  end

  // result check
  always @(posedge clk_i) begin
    quat_t   exp_q;
    matrix_t src;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (quat_queue.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        exp_q = quat_queue.pop_front();
        src   = mat_queue.pop_front();
        for (int c = 0; c < 4; c++)
          if (m_axis_tdata[c*DW +: DW] !== exp_q.q[c]) begin
            $error("%s expected %0d got %0d", q_names[c], exp_q.q[c],
                   $signed(m_axis_tdata[c*DW +: DW]));
            fail_count++;
          end
        if (m_axis_tuser[1:0] !== exp_q.branch) begin
          $error("branch_taken expected %0d got %0d", exp_q.branch, m_axis_tuser[1:0]);
          fail_count++;
        end
        if (m_axis_tuser[2] !== exp_q.degen) begin
          $error("degenerate expected %0d got %0d", exp_q.degen, m_axis_tuser[2]);
          fail_count++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (quat_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (fail_count == 0 && quat_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // timeout
  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion_top.sv
sim/tb.sv
